// File: rtl/token_bucket_packet_shaper_core_assert.svh
// Assertion macros for the token bucket shaper core
`ifndef TOKEN_BUCKET_PACKET_SHAPER_CORE_ASSERT_SVH
`define TOKEN_BUCKET_PACKET_SHAPER_CORE_ASSERT_SVH

// Check a property on every clock edge outside reset
`define TBPS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define TBPS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/tbps_pkg.sv
// Shared constants, codes and types for the token bucket shaper
`default_nettype none

package tbps_pkg;

  localparam int WAIT_DEPTH  = 16;
  localparam int READY_DEPTH = 16;

  localparam int WAIT_AW  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int READY_AW = (READY_DEPTH > 1) ? $clog2(READY_DEPTH) : 1;
  localparam int WAIT_FW  = $clog2(WAIT_DEPTH + 1);
  localparam int READY_FW = $clog2(READY_DEPTH + 1);

  localparam int OP_W     = 2;
  localparam int ID_W     = 16;
  localparam int TOK_W    = 16;
  localparam int SVC_W    = 16;
  localparam int STATUS_W = 3;
  localparam int LIMIT_W  = 31;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 31;

  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_ARRIVE = 2'd1;
  localparam logic [OP_W-1:0] OP_SERVE  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_QUEUED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OVERSIZE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REFUSED  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_QFULL    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_SERVED   = 3'd6;
  localparam logic [STATUS_W-1:0] ST_NONE     = 3'd7;

  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_DEPTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ARRIVAL_LIMIT = 1'd1;

  localparam logic [TOK_W-1:0] BUCKET_DEPTH_RST  = 16'd10;
  localparam logic [LIMIT_W-1:0] ARRIVAL_LIMIT_RST = 31'd20;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [TOK_W-1:0] need;
    logic [SVC_W-1:0] svc;
  } wait_entry_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [SVC_W-1:0] svc;
  } ready_entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TOK_W-1:0]    token_level;
    logic                moved;
    logic [ID_W-1:0]     moved_packet_id;
    logic [ID_W-1:0]     served_packet_id;
    logic [SVC_W-1:0]    served_service_time;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/tbps_ifs.sv
// Word channels of the token bucket shaper: request, result and config write
`default_nettype none

interface tbps_req_if;
  logic                       valid;
  logic                       ready;
  logic [tbps_pkg::OP_W-1:0]  operation;
  logic [tbps_pkg::ID_W-1:0]  packet_id;
  logic [tbps_pkg::TOK_W-1:0] tokens_needed;
  logic [tbps_pkg::SVC_W-1:0] service_time;

  modport source (output valid, operation, packet_id, tokens_needed, service_time,
                  input ready);
  modport sink (input valid, operation, packet_id, tokens_needed, service_time,
                output ready);
endinterface

interface tbps_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [tbps_pkg::STATUS_W-1:0] status;
  logic [tbps_pkg::TOK_W-1:0]    token_level;
  logic                          moved;
  logic [tbps_pkg::ID_W-1:0]     moved_packet_id;
  logic [tbps_pkg::ID_W-1:0]     served_packet_id;
  logic [tbps_pkg::SVC_W-1:0]    served_service_time;

  modport source (output valid, status, token_level, moved, moved_packet_id,
                  served_packet_id, served_service_time, input ready);
  modport sink (input valid, status, token_level, moved, moved_packet_id,
                served_packet_id, served_service_time, output ready);
endinterface

interface tbps_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tbps_pkg::CFG_IDX_W-1:0]  index;
  logic [tbps_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/tbps_wait_queue.sv
// Wait queue: circular store of packets waiting for tokens
`default_nettype none

module tbps_wait_queue (
  input  wire                        clk,
  input  wire                        rst,
  input  wire tbps_pkg::q_ctrl_t     ctrl,
  input  wire tbps_pkg::wait_entry_t wdata,
  output tbps_pkg::wait_entry_t      head_entry,
  output tbps_pkg::q_stat_t          stat
);
  import tbps_pkg::*;

  wait_entry_t        store [WAIT_DEPTH];
  logic [WAIT_AW-1:0] head;
  logic [WAIT_AW-1:0] tail;
  logic [WAIT_FW-1:0] fill;

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      store[tail] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      if (ctrl.push) begin
        tail <= (tail == WAIT_AW'(WAIT_DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (ctrl.pop) begin
        head <= (head == WAIT_AW'(WAIT_DEPTH - 1)) ? '0 : head + 1'b1;
      end
      unique case ({ctrl.push, ctrl.pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  assign head_entry = store[head];
  assign stat.empty = (fill == '0);
  assign stat.full  = (fill == WAIT_FW'(WAIT_DEPTH));

endmodule

`default_nettype wire

// File: rtl/tbps_ready_queue.sv
// Ready queue: circular store of packets cleared for the server
`default_nettype none

module tbps_ready_queue (
  input  wire                         clk,
  input  wire                         rst,
  input  wire tbps_pkg::q_ctrl_t      ctrl,
  input  wire tbps_pkg::ready_entry_t wdata,
  output tbps_pkg::ready_entry_t      head_entry,
  output tbps_pkg::q_stat_t           stat
);
  import tbps_pkg::*;

  ready_entry_t        store [READY_DEPTH];
  logic [READY_AW-1:0] head;
  logic [READY_AW-1:0] tail;
  logic [READY_FW-1:0] fill;

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      store[tail] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      if (ctrl.push) begin
        tail <= (tail == READY_AW'(READY_DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (ctrl.pop) begin
        head <= (head == READY_AW'(READY_DEPTH - 1)) ? '0 : head + 1'b1;
      end
      unique case ({ctrl.push, ctrl.pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  assign head_entry = store[head];
  assign stat.empty = (fill == '0);
  assign stat.full  = (fill == READY_FW'(READY_DEPTH));

endmodule

`default_nettype wire

// File: rtl/token_bucket_packet_shaper_core.sv
// Token bucket shaper core: bucket, arrival limit, wait and ready queues
//
//   channel | dir | word carries
//   --------+-----+---------------------------------------------------------
//   req     | in  | operation, packet_id, tokens_needed, service_time
//   rsp     | out | status, token_level, moved, moved_packet_id, served_*
//   cfg     | in  | index (0 bucket_depth, 1 arrival_limit), data
//
// One word per cycle while rsp does not stall: a request word lands in the input register,
// is executed once the output register has room and its result lands in the output register.
// rsp.valid rises once the word has passed the input and output registers; rsp is accepted no earlier.
// A stalled rsp holds the pending request word; req.ready drops only then.
// Reset clears the bucket, arrival count and both queues; cfg is always ready.
`default_nettype none

module token_bucket_packet_shaper_core (
  input wire       clk,
  input wire       rst,
  tbps_req_if.sink   req,
  tbps_rsp_if.source rsp,
  tbps_cfg_if.sink   cfg
);
  import tbps_pkg::*;

  logic [TOK_W-1:0]   bucket_depth;
  logic [LIMIT_W-1:0] arrival_limit;
  logic [TOK_W-1:0]   token_count;
  logic [LIMIT_W-1:0] arrivals_seen;

  logic               q_valid;
  logic [OP_W-1:0]    q_op;
  wait_entry_t        q_pkt;

  logic               r_valid;
  result_t            r_res;

  logic               exec;
  q_ctrl_t            wq_ctrl;
  q_ctrl_t            rq_ctrl;
  q_stat_t            wq_stat;
  q_stat_t            rq_stat;
  wait_entry_t        wq_head;
  ready_entry_t       rq_head;
  ready_entry_t       rq_wdata;
  wait_entry_t        head_sel;

  logic [STATUS_W-1:0] status;
  logic                attempt;
  logic                w_push;
  logic                r_pop;
  logic                move;
  logic [TOK_W-1:0]    tok_pre;
  logic [TOK_W-1:0]    token_count_next;
  logic [LIMIT_W-1:0]  arrivals_seen_next;
  result_t             res_next;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_depth  <= BUCKET_DEPTH_RST;
      arrival_limit <= ARRIVAL_LIMIT_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_BUCKET_DEPTH:  bucket_depth  <= cfg.data[TOK_W-1:0];
        CFG_ARRIVAL_LIMIT: arrival_limit <= cfg.data[LIMIT_W-1:0];
        default:           bucket_depth  <= bucket_depth;
      endcase
    end
  end

  assign exec      = q_valid && (!r_valid || rsp.ready);
  assign req.ready = !q_valid || exec;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (req.ready) begin
      q_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      q_op       <= req.operation;
      q_pkt.id   <= req.packet_id;
      q_pkt.need <= req.tokens_needed;
      q_pkt.svc  <= req.service_time;
    end
  end

  always_comb begin
    status             = ST_NONE;
    attempt            = 1'b0;
    w_push             = 1'b0;
    r_pop              = 1'b0;
    tok_pre            = token_count;
    arrivals_seen_next = arrivals_seen;
    unique case (q_op)
      OP_TICK: begin
        if (token_count < bucket_depth) begin
          tok_pre = token_count + 1'b1;
          status  = ST_ADDED;
          attempt = 1'b1;
        end else begin
          status = ST_DROPPED;
        end
      end
      OP_ARRIVE: begin
        if (arrivals_seen >= arrival_limit) begin
          status = ST_REFUSED;
        end else begin
          arrivals_seen_next = arrivals_seen + 1'b1;
          priority if (q_pkt.need > bucket_depth) begin
            status = ST_OVERSIZE;
          end else if (wq_stat.full) begin
            status = ST_QFULL;
          end else begin
            w_push  = 1'b1;
            status  = ST_QUEUED;
            attempt = 1'b1;
          end
        end
      end
      OP_SERVE: begin
        if (!rq_stat.empty) begin
          r_pop  = 1'b1;
          status = ST_SERVED;
        end
      end
      default: status = ST_NONE;
    endcase

    // bypass the arriving packet when the wait queue is empty
    head_sel = wq_stat.empty ? q_pkt : wq_head;
    move     = attempt && (!wq_stat.empty || w_push) && !rq_stat.full &&
               (tok_pre >= head_sel.need);
    token_count_next = move ? tok_pre - head_sel.need : tok_pre;

    rq_wdata.id  = head_sel.id;
    rq_wdata.svc = head_sel.svc;

    res_next.status              = status;
    res_next.token_level         = token_count_next;
    res_next.moved               = move;
    res_next.moved_packet_id     = move ? head_sel.id : '0;
    res_next.served_packet_id    = r_pop ? rq_head.id : '0;
    res_next.served_service_time = r_pop ? rq_head.svc : '0;
  end

  assign wq_ctrl.push = exec && w_push;
  assign wq_ctrl.pop  = exec && move;
  assign rq_ctrl.push = exec && move;
  assign rq_ctrl.pop  = exec && r_pop;

  tbps_wait_queue u_wait (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (wq_ctrl),
    .wdata      (q_pkt),
    .head_entry (wq_head),
    .stat       (wq_stat)
  );

  tbps_ready_queue u_ready (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (rq_ctrl),
    .wdata      (rq_wdata),
    .head_entry (rq_head),
    .stat       (rq_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      token_count   <= '0;
      arrivals_seen <= '0;
    end else if (exec) begin
      token_count   <= token_count_next;
      arrivals_seen <= arrivals_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (exec) begin
      r_valid <= 1'b1;
    end else if (rsp.ready) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      r_res <= res_next;
    end
  end

  assign rsp.valid               = r_valid;
  assign rsp.status              = r_res.status;
  assign rsp.token_level         = r_res.token_level;
  assign rsp.moved               = r_res.moved;
  assign rsp.moved_packet_id     = r_res.moved_packet_id;
  assign rsp.served_packet_id    = r_res.served_packet_id;
  assign rsp.served_service_time = r_res.served_service_time;

`include "token_bucket_packet_shaper_core_assert.svh"

  `TBPS_ASSERT(a_move_only_after_gain,
    rsp.valid && rsp.moved |-> (rsp.status == ST_ADDED || rsp.status == ST_QUEUED),
    "move reported without an added token or queued packet")
  `TBPS_ASSERT(a_no_move_into_full, exec && rq_stat.full |-> !move,
    "move into a full ready queue")
  `TBPS_ASSERT(a_tick_within_depth,
    exec && (q_op == OP_TICK) && (status == ST_ADDED) |=>
      (token_count <= $past(bucket_depth)),
    "added token left bucket above depth")
  `TBPS_ASSERT_ALWAYS(a_exec_needs_room, exec |-> (!r_valid || rsp.ready),
    "result register overwritten while stalled")

endmodule

`default_nettype wire

// File: tb/sv/token_bucket_packet_shaper_core_checker.sv
`timescale 1ns / 100ps
// Checker for the token bucket shaper core: predicts each result word and compares it
module token_bucket_packet_shaper_core_checker (
  input  logic       clk,
  input  logic       rst,
  tbps_req_if        req,
  tbps_rsp_if        rsp,
  tbps_cfg_if        cfg,
  output int         fail_count,
  output int         pending,
  output int         checked_count,
  output int         moved_count,
  output logic [7:0] status_seen
);
  import tbps_pkg::*;

  logic [TOK_W-1:0]   depth_reg;
  logic [LIMIT_W-1:0] limit_reg;
  logic [TOK_W-1:0]   tokens;
  logic [LIMIT_W-1:0] arrivals;
  wait_entry_t        wait_q [WAIT_DEPTH];
  int unsigned        wait_head;
  int unsigned        wait_fill;
  ready_entry_t       ready_q [READY_DEPTH];
  int unsigned        ready_head;
  int unsigned        ready_fill;
  result_t            expected_q [$];

  function automatic result_t shape_step(input logic [OP_W-1:0] op,
                                         input logic [ID_W-1:0] pid,
                                         input logic [TOK_W-1:0] need,
                                         input logic [SVC_W-1:0] svc);
    result_t     r;
    logic        try_move;
    int unsigned slot;
    r = '0;
    r.status = ST_NONE;
    try_move = 1'b0;
    case (op)
      OP_TICK: begin
        if (tokens < depth_reg) begin
          tokens = tokens + 1'b1;
          r.status = ST_ADDED;
          try_move = 1'b1;
        end else begin
          r.status = ST_DROPPED;
        end
      end
      OP_ARRIVE: begin
        if (arrivals >= limit_reg) begin
          r.status = ST_REFUSED;
        end else begin
          arrivals = arrivals + 1'b1;
          if (need > depth_reg) begin
            r.status = ST_OVERSIZE;
          end else if (wait_fill >= WAIT_DEPTH) begin
            r.status = ST_QFULL;
          end else begin
            slot = (wait_head + wait_fill) % WAIT_DEPTH;
            wait_q[slot] = '{id: pid, need: need, svc: svc};
            wait_fill++;
            r.status = ST_QUEUED;
            try_move = 1'b1;
          end
        end
      end
      OP_SERVE: begin
        if (ready_fill > 0) begin
          r.served_packet_id = ready_q[ready_head].id;
          r.served_service_time = ready_q[ready_head].svc;
          ready_head = (ready_head + 1) % READY_DEPTH;
          ready_fill--;
          r.status = ST_SERVED;
        end
      end
      default: ;
    endcase
    if (try_move && wait_fill != 0 && ready_fill < READY_DEPTH &&
        tokens >= wait_q[wait_head].need) begin
      tokens = tokens - wait_q[wait_head].need;
      slot = (ready_head + ready_fill) % READY_DEPTH;
      ready_q[slot] = '{id: wait_q[wait_head].id, svc: wait_q[wait_head].svc};
      ready_fill++;
      r.moved = 1'b1;
      r.moved_packet_id = wait_q[wait_head].id;
      wait_head = (wait_head + 1) % WAIT_DEPTH;
      wait_fill--;
    end
    r.token_level = tokens;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (rst) begin
      depth_reg = BUCKET_DEPTH_RST;
      limit_reg = ARRIVAL_LIMIT_RST;
      tokens = '0;
      arrivals = '0;
      wait_head = 0;
      wait_fill = 0;
      ready_head = 0;
      ready_fill = 0;
      status_seen = '0;
      expected_q.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        seen.status = rsp.status;
        seen.token_level = rsp.token_level;
        seen.moved = rsp.moved;
        seen.moved_packet_id = rsp.moved_packet_id;
        seen.served_packet_id = rsp.served_packet_id;
        seen.served_service_time = rsp.served_service_time;
        checked_count++;
        status_seen[seen.status] = 1'b1;
        if (seen.moved === 1'b1) moved_count++;
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result word with nothing expected, status %0d", $realtime,
                     seen.status);
        end else begin
          want = expected_q.pop_front();
          if (seen !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: mismatch (exp/got) status %0d/%0d level %0d/%0d moved %0d/%0d",
                       $realtime, want.status, seen.status, want.token_level,
                       seen.token_level, want.moved, seen.moved);
              $display("  moved_id %h/%h served_id %h/%h svc %h/%h",
                       want.moved_packet_id, seen.moved_packet_id, want.served_packet_id,
                       seen.served_packet_id, want.served_service_time,
                       seen.served_service_time);
            end
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_BUCKET_DEPTH:  depth_reg = cfg.data[TOK_W-1:0];
          CFG_ARRIVAL_LIMIT: limit_reg = cfg.data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready)
        expected_q.push_back(shape_step(req.operation, req.packet_id, req.tokens_needed,
                                        req.service_time));
    end
    pending = expected_q.size();
  end

endmodule

// File: tb/sv/token_bucket_packet_shaper_core_tb.sv
`timescale 1ns / 100ps
// Testbench top for the token bucket shaper core: stimulus, handshake idling and verdict
module token_bucket_packet_shaper_core_tb;
  import tbps_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tbps_req_if req ();
  tbps_rsp_if rsp ();
  tbps_cfg_if cfg ();

  int         fail_count;
  int         pending;
  int         checked_count;
  int         moved_count;
  logic [7:0] status_seen;

  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;
  logic             long_hold_go = 1'b0;
  logic             rsp_hold;
  int               items_sent = 0;
  int               quiet_cycles = 0;
  logic [TOK_W-1:0] cur_depth = BUCKET_DEPTH_RST;

  always #5 clk = ~clk;

  token_bucket_packet_shaper_core i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  token_bucket_packet_shaper_core_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .req           (req),
    .rsp           (rsp),
    .cfg           (cfg),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count),
    .moved_count   (moved_count),
    .status_seen   (status_seen)
  );

  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp.ready <= !rsp_hold && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    rsp_hold = 1'b0;
    @(posedge long_hold_go);
    rsp_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    rsp_hold <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL token_bucket_packet_shaper_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic [OP_W-1:0] op, input logic [ID_W-1:0] pid,
                           input logic [TOK_W-1:0] need, input logic [SVC_W-1:0] svc);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.operation <= op;
    req.packet_id <= pid;
    req.tokens_needed <= need;
    req.service_time <= svc;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    req.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    if (idx == CFG_BUCKET_DEPTH) cur_depth = data[TOK_W-1:0];
    @(negedge clk);
    cfg.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_phase(input int count, input int mode, input int w_tick, input int w_arr,
                           input int w_srv, input int need_max, input int hold_at);
    int               pick;
    logic [OP_W-1:0]  op;
    logic [TOK_W-1:0] need;
    int               need_pick;
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
      1: begin send_idle_pct = 58; recv_stall_pct <= 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct <= 58; end
      default: begin send_idle_pct = 24; recv_stall_pct <= 24; end
    endcase
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) long_hold_go = 1'b1;
      pick = $urandom_range(0, w_tick + w_arr + w_srv - 1);
      if ($urandom_range(0, 99) < 2) op = OP_UNUSED;
      else if (pick < w_tick) op = OP_TICK;
      else if (pick < w_tick + w_arr) op = OP_ARRIVE;
      else op = OP_SERVE;
      need_pick = $urandom_range(0, 99);
      if (need_pick < 80) need = TOK_W'($urandom_range(0, need_max));
      else if (need_pick < 90) need = TOK_W'($urandom);
      else if (need_pick < 95) need = cur_depth;
      else need = cur_depth + 1'b1;
      send_word(op, ID_W'($urandom), need, SVC_W'($urandom));
    end
    wait_idle();
  endtask

  initial begin
    req.valid = 1'b0;
    req.operation = OP_TICK;
    req.packet_id = '0;
    req.tokens_needed = '0;
    req.service_time = '0;
    cfg.valid = 1'b0;
    cfg.index = CFG_BUCKET_DEPTH;
    cfg.data = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_word(OP_SERVE, '0, '0, '0);
    send_word(OP_UNUSED, '1, '1, '1);
    send_word(OP_TICK, '0, '0, '0);
    send_word(OP_ARRIVE, 16'hFFFF, 16'd0, 16'hFFFF);
    send_word(OP_ARRIVE, 16'h1234, 16'hFFFF, 16'h0000);
    send_word(OP_ARRIVE, 16'h0000, 16'd10, 16'h0000);
    repeat (10) send_word(OP_TICK, '0, '0, '0);
    repeat (3) send_word(OP_SERVE, '0, '0, '0);
    wait_idle();

    run_phase(60, 1, 20, 70, 10, 4, -1);
    write_reg(CFG_ARRIVAL_LIMIT, 31'h7FFF_FFFF);
    write_reg(CFG_BUCKET_DEPTH, 31'd3);
    run_phase(200, 2, 60, 30, 10, 3, -1);
    write_reg(CFG_BUCKET_DEPTH, 31'd8);
    write_reg(CFG_ARRIVAL_LIMIT, 31'($urandom_range(32'h4000_0000, 32'h7FFF_FFFE)));
    run_phase(200, 3, 15, 70, 15, 8, -1);
    write_reg(CFG_BUCKET_DEPTH, 31'd65535);
    write_reg(CFG_ARRIVAL_LIMIT, 31'h7FFF_FFFF);
    run_phase(200, 0, 40, 35, 25, 5, 60);
    write_reg(CFG_BUCKET_DEPTH, 31'd1);
    run_phase(150, 1, 35, 35, 30, 1, -1);
    write_reg(CFG_BUCKET_DEPTH, 31'd40);
    run_phase(60, 2, 100, 0, 0, 0, -1);
    write_reg(CFG_BUCKET_DEPTH, 31'd2);
    run_phase(150, 3, 40, 30, 30, 2, -1);
    write_reg(CFG_BUCKET_DEPTH, 31'd0);
    run_phase(50, 0, 40, 40, 20, 0, -1);
    write_reg(CFG_BUCKET_DEPTH, 31'd10);
    write_reg(CFG_ARRIVAL_LIMIT, 31'd1);
    run_phase(50, 1, 30, 50, 20, 10, -1);
    write_reg(CFG_BUCKET_DEPTH, 31'($urandom_range(1, 65535)));
    write_reg(CFG_ARRIVAL_LIMIT, 31'h7FFF_FFFF);
    run_phase(130, 2, 35, 35, 30, 6, -1);
    repeat (10) @(negedge clk);

    $display("Run sent %0d request words through reset defaults and nine register settings;",
             items_sent);
    $display("%0d result words checked, %0d moves, status codes hit (7..0): %b",
             checked_count, moved_count, status_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS token_bucket_packet_shaper_core");
    end else begin
      $display("FAIL token_bucket_packet_shaper_core");
    end
    $finish;
  end

endmodule
